// File: src/pcfd_pkg.sv
// ----------------------------------------------------------------------------
// pcfd_pkg: shared types and constants of the packet counter field detector
// Field widths, action codes and the per-position state entry.
// ----------------------------------------------------------------------------
package pcfd_pkg;

	localparam int POS_W       = 6;
	localparam int BYTE_W      = 8;
	localparam int STEP_W      = BYTE_W + 1;
	localparam int SEEN_W      = 2;
	localparam int WIN_W       = 7;
	localparam int MAX_POS_DEF = 64;

	localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(64);

	localparam logic              ACT_SAMPLE = 1'b0;
	localparam logic              ACT_QUERY  = 1'b1;

	localparam logic [SEEN_W-1:0] SEEN_NONE  = 2'd0;
	localparam logic [SEEN_W-1:0] SEEN_ONE   = 2'd1;
	localparam logic [SEEN_W-1:0] SEEN_TWO   = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0]        last_byte;
		logic signed [STEP_W-1:0] last_step;
		logic [SEEN_W-1:0]        seen_count;
		logic                     increase_flag;
		logic                     broken_flag;
	} entry_t;

endpackage

// File: src/pcfd_req_if.sv
// ----------------------------------------------------------------------------
// pcfd_req_if: request channel of the packet counter field detector
// Valid/ready handshake carrying one sample or query request.
// ----------------------------------------------------------------------------
interface pcfd_req_if import pcfd_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              action;
	logic [POS_W-1:0]  position;
	logic [BYTE_W-1:0] byte_value;

	modport source (output valid, output action, output position, output byte_value,
		input ready);
	modport sink (input valid, input action, input position, input byte_value,
		output ready);

endinterface

// File: src/pcfd_rsp_if.sv
// ----------------------------------------------------------------------------
// pcfd_rsp_if: response channel of the packet counter field detector
// Valid/ready handshake carrying one query answer.
// ----------------------------------------------------------------------------
interface pcfd_rsp_if import pcfd_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  queried_position;
	logic              is_counter;
	logic              ever_increased;
	logic              pattern_broken;
	logic [SEEN_W-1:0] samples_seen;

	modport source (output valid, output queried_position, output is_counter,
		output ever_increased, output pattern_broken, output samples_seen, input ready);
	modport sink (input valid, input queried_position, input is_counter,
		input ever_increased, input pattern_broken, input samples_seen, output ready);

endinterface

// File: src/packet_counter_field_detector.sv
// ----------------------------------------------------------------------------
// packet_counter_field_detector: finds header byte positions that count up
// Per-position state lives in a memory; each sample is a read-modify-write, each query a read.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    action, position, byte_value
//   rsp      out        valid/ready    queried_position, flags, samples_seen
//   cfg      in         cfg_wr_en      cfg_wr_data (window_length)
//
// One request is accepted every cycle unless a query stalls in stage one; the state
// memory is read at acceptance and written back from stage one for samples.
// A query answer is taken from stage one into the rsp register once rsp is free.
// Reset clears the per-position valid bits at once; window_length returns to 64.
// A stalled rsp holds a query in stage one and drops req.ready; samples never stall.
// ----------------------------------------------------------------------------
module packet_counter_field_detector import pcfd_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [WIN_W-1:0] cfg_wr_data,
	pcfd_req_if.sink         req,
	pcfd_rsp_if.source       rsp
);

	localparam int DEPTH = (MAX_POSITIONS < (2 ** POS_W)) ? MAX_POSITIONS : (2 ** POS_W);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIN_W-1:0]  window_q;
	logic [DEPTH-1:0]  valid_q;
	entry_t            mem [DEPTH];

	logic              accept;
	logic              in_window;
	logic [IDX_W-1:0]  rd_idx;

	logic              vld_s1;
	logic              action_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [BYTE_W-1:0] byte_s1;
	entry_t            rd_s1;
	logic              rd_vld_s1;
	logic              fwd_s1;
	entry_t            fwd_entry_s1;

	entry_t            cur;
	entry_t            nxt;
	logic              s1_adv;
	logic              wr_en;
	logic              rsp_load;

	logic              rsp_vld_q;
	logic [POS_W-1:0]  rsp_pos_q;
	logic              rsp_inc_q;
	logic              rsp_brk_q;
	logic [SEEN_W-1:0] rsp_seen_q;

	assign in_window = ({1'b0, req.position} < window_q) &&
		(32'(req.position) < MAX_POSITIONS);
	assign rd_idx    = req.position[IDX_W-1:0];

	assign rsp_load  = vld_s1 && (action_s1 == ACT_QUERY) && (!rsp_vld_q || rsp.ready);
	assign s1_adv    = !vld_s1 || (action_s1 == ACT_SAMPLE) || rsp_load;
	assign wr_en     = vld_s1 && (action_s1 == ACT_SAMPLE);
	assign req.ready = s1_adv;
	assign accept    = req.valid && req.ready;

	always_comb begin
		cur = fwd_s1 ? fwd_entry_s1 : rd_s1;
		if (!(fwd_s1 || rd_vld_s1)) begin
			cur.seen_count    = SEEN_NONE;
			cur.increase_flag = 1'b0;
			cur.broken_flag   = 1'b0;
		end
	end

	pcfd_update u_update (
		.cur        (cur),
		.byte_value (byte_s1),
		.nxt        (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1        <= mem[rd_idx];
			action_s1    <= req.action;
			pos_s1       <= req.position;
			idx_s1       <= rd_idx;
			byte_s1      <= req.byte_value;
			fwd_entry_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			vld_s1    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if (accept) begin
				vld_s1    <= in_window;
				rd_vld_s1 <= valid_q[rd_idx];
				fwd_s1    <= wr_en && (idx_s1 == rd_idx);
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_pos_q  <= pos_s1;
			rsp_inc_q  <= cur.increase_flag;
			rsp_brk_q  <= cur.broken_flag;
			rsp_seen_q <= cur.seen_count;
		end
	end

	assign rsp.valid            = rsp_vld_q;
	assign rsp.queried_position = rsp_pos_q;
	assign rsp.is_counter       = rsp_inc_q && !rsp_brk_q;
	assign rsp.ever_increased   = rsp_inc_q;
	assign rsp.pattern_broken   = rsp_brk_q;
	assign rsp.samples_seen     = rsp_seen_q;

	a_flags_need_two: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.ever_increased || rsp.pattern_broken) |->
			rsp.samples_seen == SEEN_TWO)
		else $error("flags set with fewer than two samples");

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (nxt.seen_count == SEEN_ONE) || (nxt.seen_count == SEEN_TWO))
		else $error("written sample count out of range");

	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(idx_s1)])
		else $error("valid bit not set after write-back");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept && wr_en && (idx_s1 == rd_idx) |=> fwd_s1)
		else $error("missing forward on back-to-back same position");

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (action_s1 == ACT_QUERY) && rsp_vld_q && !rsp.ready |-> !req.ready)
		else $error("request accepted while query stalled");

endmodule

// File: src/pcfd_update.sv
// ----------------------------------------------------------------------------
// pcfd_update: per-position state update for one sampled byte
// Computes the new step, compares it with the previous one and sets flags.
// ----------------------------------------------------------------------------
module pcfd_update import pcfd_pkg::*; (
	input  entry_t            cur,
	input  logic [BYTE_W-1:0] byte_value,
	output entry_t            nxt
);

	logic signed [STEP_W-1:0] step;
	logic signed [STEP_W-1:0] prev;
	logic                     keep;
	logic                     prev_pos;

	assign step     = $signed({1'b0, byte_value}) - $signed({1'b0, cur.last_byte});
	assign prev     = cur.last_step;
	assign keep     = (prev == step) || (prev == '0) || (step == '0);
	assign prev_pos = !prev[STEP_W-1] && (prev != '0);

	always_comb begin
		nxt = cur;
		if (cur.seen_count == SEEN_NONE) begin
			nxt.last_byte  = byte_value;
			nxt.seen_count = SEEN_ONE;
		end else begin
			if (cur.seen_count[1]) begin
				if (keep) begin
					if (prev_pos) begin
						nxt.increase_flag = 1'b1;
					end
				end else begin
					nxt.broken_flag = 1'b1;
				end
			end
			nxt.last_step  = step;
			nxt.last_byte  = byte_value;
			nxt.seen_count = SEEN_TWO;
		end
	end

endmodule
